// ===== rtl/plnaf_pkg.sv =====
// ----------------------------------------------------------------------------
// plnaf_pkg
// types, constants and microcode for the power-law noise AR filter
// ----------------------------------------------------------------------------
package plnaf_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int OUT_W      = 24;
   localparam int COEF_W     = 18;
   localparam int POLES_W    = 3;
   localparam int NCOEF      = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;
   localparam int FRAC_BITS  = 16;
   localparam int PROD_W     = COEF_W + OUT_W;
   // sample << 16 plus five products of 2^40 stays below 2^44
   localparam int ACC_W      = 45;
   localparam int Y_W        = ACC_W - FRAC_BITS;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_COEF_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_4 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_POLES  = 3'd5;

   localparam logic [POLES_W-1:0] POLES_RESET = 3'd5;

   localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [Y_W-1:0]    Y_MAX      = Y_W'(8388607);
   localparam logic signed [Y_W-1:0]    Y_MIN      = -Y_W'(8388608);
   localparam logic signed [OUT_W-1:0]  OUT_MAX    = 24'sh7fffff;
   localparam logic signed [OUT_W-1:0]  OUT_MIN    = 24'sh800000;

   typedef enum logic [1:0] {
      STEP_WAIT,
      STEP_MAC,
      STEP_FIN
   } step_type;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_MAC,
      OP_FIN
   } op_type;

   typedef enum logic [1:0] {
      COND_NO_BEAT,
      COND_MORE,
      COND_OUT_BUSY
   } cond_type;

   // one control word of the program
   typedef struct packed {
      op_type   op;
      logic     ready;
      logic     k_clr;
      logic     k_inc;
      cond_type cond;
      step_type jmp;
      step_type nxt;
   } uword_type;

   // datapath strobes from the sequencer
   typedef struct packed {
      logic load;
      logic mac;
      logic fin;
   } ctrl_type;

   function automatic uword_type ucode(step_type step);
      uword_type w;
      unique case (step)
         STEP_WAIT: w = '{op: OP_LOAD, ready: 1'b1, k_clr: 1'b1, k_inc: 1'b0,
                          cond: COND_NO_BEAT, jmp: STEP_WAIT, nxt: STEP_MAC};
         STEP_MAC:  w = '{op: OP_MAC, ready: 1'b0, k_clr: 1'b0, k_inc: 1'b1,
                          cond: COND_MORE, jmp: STEP_MAC, nxt: STEP_FIN};
         STEP_FIN:  w = '{op: OP_FIN, ready: 1'b0, k_clr: 1'b0, k_inc: 1'b0,
                          cond: COND_OUT_BUSY, jmp: STEP_FIN, nxt: STEP_WAIT};
         default:   w = '{op: OP_LOAD, ready: 1'b0, k_clr: 1'b1, k_inc: 1'b0,
                          cond: COND_NO_BEAT, jmp: STEP_WAIT, nxt: STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/plnaf_if.sv =====
// ----------------------------------------------------------------------------
// plnaf channel interfaces
// valid/ready channels for the white input and the colored result
// ----------------------------------------------------------------------------
interface plnaf_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [plnaf_pkg::SAMPLE_W-1:0]  white_sample;

   modport source (output valid, output white_sample, input ready);
   modport sink   (input valid, input white_sample, output ready);
endinterface

interface plnaf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [plnaf_pkg::OUT_W-1:0]  colored_sample;
   logic                                saturated;

   modport source (output valid, output colored_sample, output saturated, input ready);
   modport sink   (input valid, input colored_sample, input saturated, output ready);
endinterface

// ===== rtl/plnaf_seq.sv =====
// ----------------------------------------------------------------------------
// plnaf_seq
// step counter, microcode rom and pole counter
// ----------------------------------------------------------------------------
module plnaf_seq #(
   parameter int POLES = 5,
   parameter int KW    = (POLES > 1) ? $clog2(POLES) : 1,
   parameter int CW    = $clog2(POLES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    out_busy,
   input  logic [CW-1:0]           pole_cnt,
   output logic                    req_ready,
   output plnaf_pkg::ctrl_type     ctrl,
   output logic [KW-1:0]           pole_idx
);

   plnaf_pkg::step_type  step_ff, step_in;
   plnaf_pkg::uword_type uw;
   logic [KW-1:0]        k_ff, k_in;
   logic                 more;
   logic                 hit;

   assign uw   = plnaf_pkg::ucode(step_ff);
   assign more = (int'(k_ff) + 1) < int'(pole_cnt);

   always_comb begin
      unique case (uw.cond)
         plnaf_pkg::COND_NO_BEAT:  hit = !req_valid;
         plnaf_pkg::COND_MORE:     hit = more;
         plnaf_pkg::COND_OUT_BUSY: hit = out_busy;
         default:                  hit = 1'b0;
      endcase
      step_in = hit ? uw.jmp : uw.nxt;
      if (uw.k_clr) begin
         k_in = '0;
      end else if (uw.k_inc && more) begin
         k_in = k_ff + KW'(1);
      end else begin
         k_in = k_ff;
      end
   end

   always_comb begin
      req_ready = uw.ready;
      pole_idx  = k_ff;
      ctrl.load = (uw.op == plnaf_pkg::OP_LOAD) && uw.ready && req_valid;
      ctrl.mac  = (uw.op == plnaf_pkg::OP_MAC);
      ctrl.fin  = (uw.op == plnaf_pkg::OP_FIN) && !out_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= plnaf_pkg::STEP_WAIT;
         k_ff    <= '0;
      end else begin
         step_ff <= step_in;
         k_ff    <= k_in;
      end
   end

endmodule

// ===== rtl/plnaf_dp.sv =====
// ----------------------------------------------------------------------------
// plnaf_dp
// shared multiply-accumulate, rounding, saturation, history and result register
// ----------------------------------------------------------------------------
module plnaf_dp #(
   parameter int POLES = 5,
   parameter int KW    = (POLES > 1) ? $clog2(POLES) : 1
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  plnaf_pkg::ctrl_type                     ctrl,
   input  logic [KW-1:0]                           pole_idx,
   input  logic signed [plnaf_pkg::COEF_W-1:0]     coef [plnaf_pkg::NCOEF],
   input  logic signed [plnaf_pkg::SAMPLE_W-1:0]   white_sample,
   input  logic                                    rsp_ready,
   output logic                                    out_busy,
   output logic                                    rsp_valid,
   output logic signed [plnaf_pkg::OUT_W-1:0]      colored_sample,
   output logic                                    saturated
);

   logic signed [plnaf_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [plnaf_pkg::PROD_W-1:0] prod;
   logic signed [plnaf_pkg::COEF_W-1:0] coef_sel;
   logic signed [plnaf_pkg::OUT_W-1:0]  hist_sel;
   logic signed [plnaf_pkg::OUT_W-1:0]  hist_ff [POLES];
   logic signed [plnaf_pkg::ACC_W-1:0]  rnd;
   logic signed [plnaf_pkg::Y_W-1:0]    y;
   logic signed [plnaf_pkg::OUT_W-1:0]  y_sat;
   logic                                sat;
   logic                                valid_ff, valid_in;
   logic signed [plnaf_pkg::OUT_W-1:0]  sample_ff;
   logic                                sat_ff;

   assign coef_sel = coef[pole_idx];
   assign hist_sel = hist_ff[pole_idx];
   assign prod     = coef_sel * hist_sel;

   always_comb begin
      if (ctrl.load) begin
         acc_in = plnaf_pkg::ACC_W'(white_sample) <<< plnaf_pkg::FRAC_BITS;
      end else if (ctrl.mac) begin
         acc_in = acc_ff - plnaf_pkg::ACC_W'(prod);
      end else begin
         acc_in = acc_ff;
      end
   end

   // round half up, then clip to 24 bits
   always_comb begin
      rnd = acc_ff + plnaf_pkg::ROUND_HALF;
      y   = $signed(rnd[plnaf_pkg::ACC_W-1:plnaf_pkg::FRAC_BITS]);
      sat = 1'b1;
      if (y > plnaf_pkg::Y_MAX) begin
         y_sat = plnaf_pkg::OUT_MAX;
      end else if (y < plnaf_pkg::Y_MIN) begin
         y_sat = plnaf_pkg::OUT_MIN;
      end else begin
         y_sat = y[plnaf_pkg::OUT_W-1:0];
         sat   = 1'b0;
      end
   end

   always_comb begin
      if (ctrl.fin) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (ctrl.fin) begin
         sample_ff <= y_sat;
         sat_ff    <= sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int i = 0; i < POLES; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         if (ctrl.fin) begin
            hist_ff[0] <= y_sat;
            for (int i = 1; i < POLES; i++) begin
               hist_ff[i] <= hist_ff[i-1];
            end
         end
      end
   end

   assign out_busy       = valid_ff && !rsp_ready;
   assign rsp_valid      = valid_ff;
   assign colored_sample = sample_ff;
   assign saturated      = sat_ff;

endmodule

// ===== rtl/power_law_noise_ar_filter.sv =====
// ----------------------------------------------------------------------------
// power_law_noise_ar_filter
// autoregressive 1/f^alpha noise shaper, one shared multiplier under microcode
// ----------------------------------------------------------------------------
// sequence: the input beat loads the accumulator, one mac step per active pole
//   (P = active poles) follows, and the finish step registers the result beat
// the single multiply-accumulate unit takes one pole per cycle, one sample at a time
// a new input beat is taken while a finished result still waits on rsp
// reset: synchronous, clears history, coefficients to 0, active_poles to 5
// ----------------------------------------------------------------------------
module power_law_noise_ar_filter #(
   parameter int POLES = 5
) (
   input  logic                                  clock,
   input  logic                                  reset,
   plnaf_req_if.sink                             req_if,
   plnaf_rsp_if.source                           rsp_if,
   input  logic                                  csr_we,
   input  logic [plnaf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [plnaf_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int KW = (POLES > 1) ? $clog2(POLES) : 1;
   localparam int CW = $clog2(POLES + 1);

   // config registers
   logic signed [plnaf_pkg::COEF_W-1:0] coef_ff [plnaf_pkg::NCOEF];
   logic [plnaf_pkg::POLES_W-1:0]       poles_ff;

   // clamped pole count, 1..POLES
   logic [CW-1:0]        pole_cnt;
   plnaf_pkg::ctrl_type  ctrl;
   logic [KW-1:0]        pole_idx;
   logic                 out_busy;

   always_comb begin
      if (poles_ff == '0) begin
         pole_cnt = CW'(1);
      end else if (int'(poles_ff) > POLES) begin
         pole_cnt = CW'(POLES);
      end else begin
         pole_cnt = CW'(poles_ff);
      end
   end

   // register writes; unknown indexes fall through and are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < plnaf_pkg::NCOEF; i++) begin
            coef_ff[i] <= '0;
         end
         poles_ff <= plnaf_pkg::POLES_RESET;
      end else if (csr_we) begin
         if (csr_index <= plnaf_pkg::REG_COEF_4) begin
            coef_ff[csr_index] <= $signed(csr_wdata[plnaf_pkg::COEF_W-1:0]);
         end else if (csr_index == plnaf_pkg::REG_POLES) begin
            poles_ff <= csr_wdata[plnaf_pkg::POLES_W-1:0];
         end
      end
   end

   // microcode sequencer: wait for beat, one mac step per pole, finish
   plnaf_seq #(
      .POLES (POLES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .out_busy  (out_busy),
      .pole_cnt  (pole_cnt),
      .req_ready (req_if.ready),
      .ctrl      (ctrl),
      .pole_idx  (pole_idx)
   );

   // datapath with history line and result register
   plnaf_dp #(
      .POLES (POLES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .pole_idx       (pole_idx),
      .coef           (coef_ff),
      .white_sample   (req_if.white_sample),
      .rsp_ready      (rsp_if.ready),
      .out_busy       (out_busy),
      .rsp_valid      (rsp_if.valid),
      .colored_sample (rsp_if.colored_sample),
      .saturated      (rsp_if.saturated)
   );

endmodule

// ===== rtl/plnaf_checker.sv =====
// ----------------------------------------------------------------------------
// plnaf_checker
// port-level assertions for the power-law noise AR filter
// ----------------------------------------------------------------------------
module plnaf_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [plnaf_pkg::OUT_W-1:0]  colored_sample,
   input  logic                                saturated
);

   // out of reset: idle sequencer, empty result register
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("bad state after reset");

   // one sample at a time: no second beat right after an accepted one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken during computation");

   // a clipped result sits on one of the rails
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && saturated |->
         colored_sample == plnaf_pkg::OUT_MAX || colored_sample == plnaf_pkg::OUT_MIN)
      else $error("saturated flag without rail value");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(colored_sample) && $stable(saturated))
      else $error("result beat changed while stalled");

endmodule

bind power_law_noise_ar_filter plnaf_checker u_plnaf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .colored_sample (rsp_if.colored_sample),
   .saturated      (rsp_if.saturated)
);
